// ===== hdl/rijndael_256_block_cipher_core_macros.svh =====
// assertion macros shared by the rijndael-256 core rtl
// no dependencies; included by files that carry concurrent checks
`ifndef RIJNDAEL_256_BLOCK_CIPHER_CORE_MACROS_SVH
`define RIJNDAEL_256_BLOCK_CIPHER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define RJ_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("rijndael core check failed");
`define RJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rijndael core check failed");
`else
`define RJ_ASSERT(lbl, clk, rst_n, expr)
`define RJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/rj256_pkg.sv =====
// types, s-box tables and gf(2^8) helpers for the rijndael-256 core
// no dependencies
package rj256_pkg;

    localparam int NUM_ROUNDS = 14;
    localparam int KEY_ROWS   = NUM_ROUNDS + 1;

    typedef logic [255:0]        block_t;
    typedef logic [3:0]          row_idx_t;
    typedef logic [0:255][7:0]   sbox_t;

    typedef struct packed {
        logic     load;
        logic     step;
        row_idx_t row;
    } ks_ctrl_t;

    localparam sbox_t SBOX = {
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // inverse table is built from the forward one at elaboration
    function automatic sbox_t build_inv_sbox();
        sbox_t t;
        t = '0;
        for (int i = 0; i < 256; i++)
        begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam sbox_t INV_SBOX = build_inv_sbox();

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // one column, row 0 in the top byte
    function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
        logic [7:0] a [4];
        logic [7:0] m1 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [7:0] x4;
        logic [7:0] x8;
        logic [31:0] res;
        for (int k = 0; k < 4; k++)
        begin
            a[k]  = col[31 - 8 * k -: 8];
            m1[k] = a[k];
            m2[k] = xtime(a[k]);
            m3[k] = m2[k] ^ a[k];
            x4    = xtime(m2[k]);
            x8    = xtime(x4);
            m9[k] = x8 ^ a[k];
            mb[k] = x8 ^ m2[k] ^ a[k];
            md[k] = x8 ^ x4 ^ a[k];
            me[k] = x8 ^ x4 ^ m2[k];
        end
        for (int r = 0; r < 4; r++)
        begin
            if (inv)
            begin
                res[31 - 8 * r -: 8] = me[r] ^ mb[(r + 1) % 4] ^ md[(r + 2) % 4]
                                     ^ m9[(r + 3) % 4];
            end
            else
            begin
                res[31 - 8 * r -: 8] = m2[r] ^ m3[(r + 1) % 4] ^ m1[(r + 2) % 4]
                                     ^ m1[(r + 3) % 4];
            end
        end
        return res;
    endfunction

endpackage

// ===== hdl/rijndael_256_block_cipher_core.sv =====
// rijndael-256 (256-bit block, 256-bit key) core with sequencer and registers
// depends on rj256_pkg, rj256_key_sched, rj256_round and the macros header
//
// usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes key word
//   cfg_index 0..3; any write to 0..3 re-expands the key schedule, and no
//   item or write is taken while it runs. other indexes are dropped. in
//   channel carries req_type (0 encrypt, 1 decrypt) and the block; out
//   channel returns the result block.
//   an item runs from accept to result through a round-key fetch, the
//   shared round unit (key addition plus 14 rounds, one per cycle) and
//   the load into the output register. in_ready comes back the cycle
//   after that load. the first item after reset adds the expansion of the
//   all-zero key. in_ready is high only when the sequencer is idle, so one
//   item is in flight at a time. if the receiver stalls, the finished item
//   waits in the output register and the next one waits in the sequencer
//   until it drains. reset clears control state and the key registers;
//   round keys are not valid until expanded.
`include "rijndael_256_block_cipher_core_macros.svh"
module rijndael_256_block_cipher_core
    import rj256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [63:0] in_bytes_0_to_7,
    input  logic [63:0] in_bytes_8_to_15,
    input  logic [63:0] in_bytes_16_to_23,
    input  logic [63:0] in_bytes_24_to_31,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_bytes_0_to_7,
    output logic [63:0] out_bytes_8_to_15,
    output logic [63:0] out_bytes_16_to_23,
    output logic [63:0] out_bytes_24_to_31
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXPAND = 5'b00010,
        S_FETCH  = 5'b00100,
        S_ROUND  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    localparam row_idx_t LAST_ROW = row_idx_t'(NUM_ROUNDS);

    state_t      state_reg, state_next;
    row_idx_t    cnt_reg, cnt_next;
    row_idx_t    rk_addr_reg, rk_addr_next;
    logic        sched_ok_reg, sched_ok_next;
    logic        pend_reg, pend_next;
    logic        dec_reg;
    logic [63:0] key_reg [4];
    logic [63:0] key_next [4];
    block_t      st_reg;
    block_t      out_reg;
    logic        out_valid_reg, out_valid_next;
    ks_ctrl_t    ks_ctrl;
    block_t      rk_q;
    block_t      round_out;
    logic        cfg_fire;
    logic        in_fire;
    logic        key_hit;
    logic        out_load;
    row_idx_t    ahead;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;
    assign key_hit   = cfg_fire && !cfg_index[2];
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            key_next[i] = (key_hit && (cfg_index[1:0] == 2'(i))) ? cfg_data : key_reg[i];
        end
    end

    // round key index, reversed for decrypt
    function automatic row_idx_t key_row(input row_idx_t j, input logic dec);
        return dec ? (LAST_ROW - j) : j;
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rk_addr_next   = rk_addr_reg;
        sched_ok_next  = sched_ok_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        ks_ctrl        = '0;
        ks_ctrl.row    = cnt_reg;
        ahead          = cnt_reg + 4'd2;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (key_hit)
                begin
                    ks_ctrl.load = 1'b1;
                    pend_next    = 1'b0;
                    state_next   = S_EXPAND;
                end
                else if (in_fire)
                begin
                    rk_addr_next = key_row('0, req_type);
                    if (sched_ok_reg)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        ks_ctrl.load = 1'b1;
                        pend_next    = 1'b1;
                        state_next   = S_EXPAND;
                    end
                end
            end
            S_EXPAND:
            begin
                ks_ctrl.step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == LAST_ROW)
                begin
                    cnt_next      = '0;
                    sched_ok_next = 1'b1;
                    state_next    = pend_reg ? S_FETCH : S_IDLE;
                end
            end
            S_FETCH:
            begin
                rk_addr_next = key_row(4'd1, dec_reg);
                cnt_next     = '0;
                state_next   = S_ROUND;
            end
            S_ROUND:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg < LAST_ROW - 4'd1)
                begin
                    rk_addr_next = key_row(ahead, dec_reg);
                end
                if (cnt_reg == LAST_ROW)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rk_addr_reg   <= '0;
            sched_ok_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rk_addr_reg   <= rk_addr_next;
            sched_ok_reg  <= sched_ok_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= key_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dec_reg <= req_type;
            st_reg  <= {in_bytes_0_to_7, in_bytes_8_to_15, in_bytes_16_to_23,
                        in_bytes_24_to_31};
        end
        else if (state_reg == S_ROUND)
        begin
            st_reg <= (cnt_reg == '0) ? (st_reg ^ rk_q) : round_out;
        end
        if (out_load)
        begin
            out_reg <= st_reg;
        end
    end

    rj256_key_sched u_key_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ks_ctrl),
        .key     ({key_next[0], key_next[1], key_next[2], key_next[3]}),
        .rd_addr (rk_addr_reg),
        .rk_q    (rk_q)
    );

    rj256_round u_round (
        .st   (st_reg),
        .rk   (rk_q),
        .dec  (dec_reg),
        .last (cnt_reg == LAST_ROW),
        .nxt  (round_out)
    );

    assign out_valid          = out_valid_reg;
    assign out_bytes_0_to_7   = out_reg[255:192];
    assign out_bytes_8_to_15  = out_reg[191:128];
    assign out_bytes_16_to_23 = out_reg[127:64];
    assign out_bytes_24_to_31 = out_reg[63:0];

    `RJ_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_fire,
        (state_reg == S_FETCH) || (state_reg == S_EXPAND))
    `RJ_ASSERT_NEXT(a_last_round_done, clk, rst_n,
        (state_reg == S_ROUND) && (cnt_reg == LAST_ROW), state_reg == S_DONE)
    `RJ_ASSERT(a_rk_addr_range, clk, rst_n, rk_addr_reg <= LAST_ROW)
    `RJ_ASSERT(a_rounds_need_sched, clk, rst_n,
        !((state_reg == S_FETCH) || (state_reg == S_ROUND)) || sched_ok_reg)

endmodule

// ===== hdl/rj256_key_sched.sv =====
// key expansion, one 256-bit round key per cycle, and the round key memory
// depends on rj256_pkg
module rj256_key_sched
    import rj256_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ks_ctrl_t ctrl,
    input  block_t   key,
    input  row_idx_t rd_addr,
    output block_t   rk_q
);

    block_t     exp_row_reg;
    block_t     exp_row_next;
    logic [7:0] rcon_reg;
    block_t     rk_mem [KEY_ROWS];
    block_t     rk_q_reg;
    logic [31:0] p [8];
    logic [31:0] n [8];

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            p[j] = exp_row_reg[255 - 32 * j -: 32];
        end
        n[0] = p[0] ^ sub_word({p[7][23:0], p[7][31:24]}) ^ {rcon_reg, 24'h0};
        for (int j = 1; j < 8; j++)
        begin
            // the middle word gets an extra sub_word
            n[j] = p[j] ^ ((j == 4) ? sub_word(n[j - 1]) : n[j - 1]);
        end
        for (int j = 0; j < 8; j++)
        begin
            exp_row_next[255 - 32 * j -: 32] = n[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcon_reg <= 8'h01;
        end
        else if (ctrl.load)
        begin
            rcon_reg <= 8'h01;
        end
        else if (ctrl.step)
        begin
            rcon_reg <= xtime(rcon_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            exp_row_reg <= key;
        end
        else if (ctrl.step)
        begin
            exp_row_reg <= exp_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            rk_mem[ctrl.row] <= exp_row_reg;
        end
        rk_q_reg <= rk_mem[rd_addr];
    end

    assign rk_q = rk_q_reg;

endmodule

// ===== hdl/rj256_round.sv =====
// one full cipher or inverse cipher round on the 256-bit state
// depends on rj256_pkg
module rj256_round
    import rj256_pkg::*;
(
    input  block_t st,
    input  block_t rk,
    input  logic   dec,
    input  logic   last,
    output block_t nxt
);

    logic [7:0]  b  [4][8];
    logic [7:0]  s  [4][8];
    logic [31:0] col;
    logic [2:0]  off [4];
    block_t      mixed_in;
    block_t      res;

    assign off[0] = 3'd0;
    assign off[1] = 3'd1;
    assign off[2] = 3'd3;
    assign off[3] = 3'd4;

    always_comb
    begin
        col = '0;
        for (int c = 0; c < 8; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                b[r][c] = st[255 - 8 * (4 * c + r) -: 8];
            end
        end
        // row shift then byte substitution, both directions
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 8; c++)
            begin
                if (dec)
                begin
                    s[r][c] = INV_SBOX[b[r][3'(c) - off[r]]];
                end
                else
                begin
                    s[r][c] = SBOX[b[r][3'(c) + off[r]]];
                end
            end
        end
        for (int c = 0; c < 8; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                mixed_in[255 - 8 * (4 * c + r) -: 8] = s[r][c];
            end
        end
        // encrypt mixes before the key, decrypt after it
        if (dec)
        begin
            mixed_in = mixed_in ^ rk;
        end
        res = mixed_in;
        if (!last)
        begin
            for (int c = 0; c < 8; c++)
            begin
                col = mixed_in[255 - 32 * c -: 32];
                res[255 - 32 * c -: 32] = mix_col(col, dec);
            end
        end
        nxt = dec ? res : (res ^ rk);
    end

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for rijndael_256_block_cipher_core: key writes, encrypt and decrypt
// items with random idling, checked against an in-bench rijndael-256/256 predictor
// depends on hdl/rj256_pkg.sv and the core rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rj256_pkg::*;

    localparam int KEY_REG_COUNT = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;
    localparam logic [2:0] IDX_KEY_0_7   = 3'd0;
    localparam logic [2:0] IDX_KEY_8_15  = 3'd1;
    localparam logic [2:0] IDX_KEY_16_23 = 3'd2;
    localparam logic [2:0] IDX_KEY_24_31 = 3'd3;
    localparam logic [2:0] IDX_UNUSED_LO = 3'd4;
    localparam logic [2:0] IDX_UNUSED_HI = 3'd7;

    class block_scoreboard;
        block_t pending[$];
        int     errors;
        int     checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        function void note_block(block_t expected_blk);
            pending = {pending, expected_blk};
        endfunction

        function void check_block(block_t got);
            block_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result item %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            for (int f = 0; f < 4; f++)
            begin
                if (got[255 - 64 * f -: 64] !== want[255 - 64 * f -: 64])
                begin
                    $display("%0t: out_bytes field %0d expected %h actual %h", $realtime, f,
                             want[255 - 64 * f -: 64], got[255 - 64 * f -: 64]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        req_type = 1'b0;
    logic [63:0] in_bytes_0_to_7 = '0;
    logic [63:0] in_bytes_8_to_15 = '0;
    logic [63:0] in_bytes_16_to_23 = '0;
    logic [63:0] in_bytes_24_to_31 = '0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [63:0] out_bytes_0_to_7;
    logic [63:0] out_bytes_8_to_15;
    logic [63:0] out_bytes_16_to_23;
    logic [63:0] out_bytes_24_to_31;

    block_scoreboard sb = new();
    bit          quiet = 1'b0;
    int          cycle_count = 0;
    int          enc_sent = 0;
    int          dec_sent = 0;
    int          key_writes = 0;

    // predictor state
    logic [7:0]  sub_tab [256];
    logic [7:0]  inv_sub_tab [256];
    logic [63:0] key_reg [KEY_REG_COUNT];
    logic [31:0] round_words [120];

    rijndael_256_block_cipher_core i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .req_type           (req_type),
        .in_bytes_0_to_7    (in_bytes_0_to_7),
        .in_bytes_8_to_15   (in_bytes_8_to_15),
        .in_bytes_16_to_23  (in_bytes_16_to_23),
        .in_bytes_24_to_31  (in_bytes_24_to_31),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .out_bytes_0_to_7   (out_bytes_0_to_7),
        .out_bytes_8_to_15  (out_bytes_8_to_15),
        .out_bytes_16_to_23 (out_bytes_16_to_23),
        .out_bytes_24_to_31 (out_bytes_24_to_31)
    );

    function automatic logic [7:0] gf_double(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_product(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= a;
            a = gf_double(a);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rot_byte(logic [7:0] v, int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    // s-boxes from the field inverse and the affine map
    function automatic void build_sub_tables();
        logic [7:0] x;
        logic [7:0] r;
        logic [7:0] b;
        logic [7:0] y;
        for (int i = 0; i < 256; i++)
        begin
            x = 8'(i);
            r = 8'h01;
            b = x;
            for (int e = 254; e > 0; e = e >> 1)
            begin
                if (e & 1)
                    r = gf_product(r, b);
                b = gf_product(b, b);
            end
            if (x == 8'h00)
                r = 8'h00;
            y = r ^ rot_byte(r, 1) ^ rot_byte(r, 2) ^ rot_byte(r, 3) ^ rot_byte(r, 4) ^ 8'h63;
            sub_tab[i] = y;
            inv_sub_tab[y] = x;
        end
    endfunction

    function automatic logic [31:0] sub_word32(logic [31:0] w);
        return {sub_tab[w[31:24]], sub_tab[w[23:16]], sub_tab[w[15:8]], sub_tab[w[7:0]]};
    endfunction

    function automatic void expand_round_keys();
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        for (int i = 0; i < KEY_REG_COUNT; i++)
        begin
            round_words[2 * i]     = key_reg[i][63:32];
            round_words[2 * i + 1] = key_reg[i][31:0];
        end
        for (int i = 8; i < 120; i++)
        begin
            t = round_words[i - 1];
            if (i % 8 == 0)
            begin
                t = sub_word32({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = gf_double(rcon);
            end
            else if (i % 8 == 4)
            begin
                t = sub_word32(t);
            end
            round_words[i] = round_words[i - 8] ^ t;
        end
    endfunction

    // state byte (row, col) sits at input byte 4*col+row
    function automatic int byte_pos(int row, int col);
        return 255 - 8 * (4 * col + row);
    endfunction

    function automatic block_t add_key(block_t s, int rnd);
        for (int c = 0; c < 8; c++)
            for (int r = 0; r < 4; r++)
                s[byte_pos(r, c) -: 8] ^= round_words[8 * rnd + c][31 - 8 * r -: 8];
        return s;
    endfunction

    function automatic block_t sub_all(block_t s, bit inv);
        for (int n = 0; n < 32; n++)
            s[255 - 8 * n -: 8] = inv ? inv_sub_tab[s[255 - 8 * n -: 8]]
                                      : sub_tab[s[255 - 8 * n -: 8]];
        return s;
    endfunction

    function automatic block_t shift_all(block_t s, bit inv);
        block_t o;
        int     offs [4];
        int     off;
        offs = '{0, 1, 3, 4};
        o = s;
        for (int r = 1; r < 4; r++)
        begin
            off = inv ? 8 - offs[r] : offs[r];
            for (int c = 0; c < 8; c++)
                o[byte_pos(r, c) -: 8] = s[byte_pos(r, (c + off) % 8) -: 8];
        end
        return o;
    endfunction

    function automatic block_t mix_all(block_t s, bit inv);
        logic [7:0] fwd_m [4];
        logic [7:0] inv_m [4];
        logic [7:0] col [4];
        logic [7:0] acc;
        fwd_m = '{8'h02, 8'h03, 8'h01, 8'h01};
        inv_m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        for (int c = 0; c < 8; c++)
        begin
            for (int r = 0; r < 4; r++)
                col[r] = s[byte_pos(r, c) -: 8];
            for (int r = 0; r < 4; r++)
            begin
                acc = '0;
                for (int k = 0; k < 4; k++)
                    acc ^= gf_product(col[k], inv ? inv_m[(k + 4 - r) % 4]
                                                  : fwd_m[(k + 4 - r) % 4]);
                s[byte_pos(r, c) -: 8] = acc;
            end
        end
        return s;
    endfunction

    function automatic block_t predict_block(logic dec, block_t blk);
        block_t s;
        if (!dec)
        begin
            s = add_key(blk, 0);
            for (int r = 1; r <= NUM_ROUNDS; r++)
            begin
                s = shift_all(sub_all(s, 1'b0), 1'b0);
                if (r != NUM_ROUNDS)
                    s = mix_all(s, 1'b0);
                s = add_key(s, r);
            end
        end
        else
        begin
            s = add_key(blk, NUM_ROUNDS);
            for (int r = NUM_ROUNDS - 1; r >= 0; r--)
            begin
                s = add_key(sub_all(shift_all(s, 1'b1), 1'b1), r);
                if (r != 0)
                    s = mix_all(s, 1'b1);
            end
        end
        return s;
    endfunction

    function automatic block_t random_block();
        block_t b;
        for (int i = 0; i < 8; i++)
            b[32 * i +: 32] = $urandom;
        return b;
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // called right after an edge; leaves valid high for back-to-back items
    task automatic send_block(logic dec, block_t blk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        req_type          <= dec;
        in_bytes_0_to_7   <= blk[255:192];
        in_bytes_8_to_15  <= blk[191:128];
        in_bytes_16_to_23 <= blk[127:64];
        in_bytes_24_to_31 <= blk[63:0];
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_block(predict_block(dec, blk));
        if (dec)
            dec_sent++;
        else
            enc_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    // only while idle
    task automatic write_key_reg(logic [2:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= IDX_KEY_24_31)
        begin
            key_reg[idx] = value;
            expand_round_keys();
            key_writes++;
        end
        @(posedge clk);
    endtask

    task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                            logic [63:0] k3);
        drain();
        write_key_reg(IDX_KEY_0_7, k0);
        write_key_reg(IDX_KEY_8_15, k1);
        write_key_reg(IDX_KEY_16_23, k2);
        write_key_reg(IDX_KEY_24_31, k3);
    endtask

    task automatic random_items(int count);
        block_t b;
        for (int i = 0; i < count; i++)
        begin
            b = random_block();
            case ($urandom_range(0, 2))
                0: send_block(REQ_ENCRYPT, b);
                1: send_block(REQ_DECRYPT, b);
                default: send_block(REQ_DECRYPT, predict_block(REQ_ENCRYPT, b));
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_block({out_bytes_0_to_7, out_bytes_8_to_15,
                            out_bytes_16_to_23, out_bytes_24_to_31});
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
                     sb.pending.size());
            $display("rijndael_256_block_cipher_core verification failed");
            $finish;
        end
    end

    // receiver stalls
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_ready <= 1'b1;
            end
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    initial
    begin
        block_t ramp;
        for (int i = 0; i < KEY_REG_COUNT; i++)
            key_reg[i] = '0;
        build_sub_tables();
        expand_round_keys();
        for (int n = 0; n < 32; n++)
            ramp[255 - 8 * n -: 8] = 8'(n);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // blocks before any key write run on the all-zero key
        send_block(REQ_ENCRYPT, '0);
        send_block(REQ_DECRYPT, '0);
        send_block(REQ_ENCRYPT, '1);
        send_block(REQ_DECRYPT, '1);
        send_block(REQ_ENCRYPT, {32{8'h55}});
        send_block(REQ_DECRYPT, {32{8'haa}});
        send_block(REQ_ENCRYPT, ramp);
        send_block(REQ_DECRYPT, predict_block(REQ_ENCRYPT, ramp));

        // writes to unused indexes must not disturb the key
        drain();
        for (int idx = IDX_UNUSED_LO; idx <= IDX_UNUSED_HI; idx++)
            write_key_reg(3'(idx), random_word());
        send_block(REQ_ENCRYPT, ramp);
        send_block(REQ_DECRYPT, '1);

        load_key('1, '1, '1, '1);
        send_block(REQ_ENCRYPT, '0);
        send_block(REQ_DECRYPT, '1);
        send_block(REQ_ENCRYPT, ramp);
        load_key({8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07},
                 {8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f},
                 {8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17},
                 {8'h18, 8'h19, 8'h1a, 8'h1b, 8'h1c, 8'h1d, 8'h1e, 8'h1f});
        send_block(REQ_ENCRYPT, ramp);
        send_block(REQ_DECRYPT, ramp);
        send_block(REQ_ENCRYPT, '1);

        // a single key word changed between phases
        drain();
        write_key_reg(IDX_KEY_16_23, 64'h8000_0000_0000_0001);
        random_items(60);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: load_key('0, '0, '0, '0);
                1: load_key('1, '1, '1, '1);
                default: load_key(random_word(), random_word(), random_word(), random_word());
            endcase
            if ($urandom_range(0, 1))
                write_key_reg(3'($urandom_range(IDX_UNUSED_LO, IDX_UNUSED_HI)),
                              random_word());
            if (ph == 7)
                quiet = 1'b1;
            random_items(ph < 2 ? 80 : 150);
        end

        drain();
        $display("covered %0d encrypt and %0d decrypt items over %0d key register writes",
                 enc_sent, dec_sent, key_writes);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("rijndael_256_block_cipher_core verification clean");
        else
            $display("rijndael_256_block_cipher_core verification failed");
        $finish;
    end

endmodule
